>>> sv/pcrd_pkg.sv
// Package for the PCM channel remix and downmix block.
// Holds sample types, the mix gain constants and the register index codes.
// No dependencies.
package pcrd_pkg;

    localparam int NUM_CH    = 8;
    localparam int MIX_SHIFT = 15;

    typedef logic signed [15:0] sample_t;
    typedef logic signed [16:0] out_t;
    typedef logic signed [31:0] prod_t;
    typedef logic        [3:0]  count_t;
    typedef logic        [3:0]  reg_index_t;

    localparam logic signed [15:0] MIX_GAIN  = 16'sd23167;
    localparam logic        [31:0] ROUND_ADD = 32'd1 << (MIX_SHIFT - 1);
    localparam logic signed [17:0] CLAMP_HI  = 18'sd32768;
    localparam logic signed [17:0] CLAMP_LO  = -18'sd32768;

    localparam reg_index_t REG_SRC_CHANNELS = 4'd0;
    localparam reg_index_t REG_DST_CHANNELS = 4'd1;

    localparam count_t CNT_RESET = 4'd2;

endpackage

>>> sv/pcm_channel_remix_downmix.sv
// Top level of the PCM channel remix and surround-to-stereo downmix block.
// Four-stage pipeline: mask, multiply, round, sum and clamp.
// Depends on pcrd_pkg.
//
// Usage:
//   The s_ channel carries one interleaved frame of eight signed 16-bit
//   samples and a last-frame mark per beat. The m_ channel returns one
//   remixed frame of eight signed 17-bit channels per beat, in units of
//   1/32768, with the last-frame mark copied through.
//   The cfg channel writes src_channels (index 0) and dst_channels
//   (index 1); writes to other indexes are dropped. cfg_ready is always
//   high. Write only while no frame is in flight.
//   With two output channels and three or more source channels, center,
//   rear left and rear right are scaled by 23167/32768 (rounded to nearest,
//   ties away from zero) and added to left and right, then clamped to
//   plus or minus 32768. Otherwise shared channels are copied and the
//   rest are zero.
//   Throughput is one frame per cycle while m_ready is high; the three constant
//   multipliers in the second stage take a new frame every cycle it advances.
//   Reset clears all valid bits and sets both channel counts to 2.
//   When the receiver holds m_ready low, each stage keeps its frame and
//   the pipeline fills its bubbles before s_ready drops.
module pcm_channel_remix_downmix
    import pcrd_pkg::*;
#(
    parameter int MAX_CHANNELS = 8
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  reg_index_t cfg_index,
    input  count_t     cfg_data,

    input  logic       s_valid,
    output logic       s_ready,
    input  sample_t    s_sample_0,
    input  sample_t    s_sample_1,
    input  sample_t    s_sample_2,
    input  sample_t    s_sample_3,
    input  sample_t    s_sample_4,
    input  sample_t    s_sample_5,
    input  sample_t    s_sample_6,
    input  sample_t    s_sample_7,
    input  logic       s_frame_last,

    output logic       m_valid,
    input  logic       m_ready,
    output out_t       m_out_0,
    output out_t       m_out_1,
    output out_t       m_out_2,
    output out_t       m_out_3,
    output out_t       m_out_4,
    output out_t       m_out_5,
    output out_t       m_out_6,
    output out_t       m_out_7,
    output logic       m_out_last
);

    localparam count_t CNT_MAX = count_t'(MAX_CHANNELS);

    count_t src_reg;
    count_t dst_reg;

    logic   v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic   adv1, adv2, adv3, adv_o;

    sample_t    in_smp [NUM_CH];
    count_t     ns, nd;
    sample_t    smp1_next [NUM_CH];
    logic [NUM_CH-1:0] keep1_next;
    logic       mix1_next;

    sample_t    smp1_reg [NUM_CH];
    logic [NUM_CH-1:0] keep1_reg;
    logic       mix1_reg;
    logic       last1_reg;

    sample_t    smp2_reg [NUM_CH];
    logic [NUM_CH-1:0] keep2_reg;
    logic       mix2_reg;
    logic       last2_reg;
    prod_t      prod_c_reg, prod_l_reg, prod_r_reg;

    sample_t    smp3_reg [NUM_CH];
    logic [NUM_CH-1:0] keep3_reg;
    logic       mix3_reg;
    logic       last3_reg;
    out_t       term_c_reg, term_l_reg, term_r_reg;
    out_t       term_c_next, term_l_next, term_r_next;

    logic signed [17:0] sum_l, sum_r;
    out_t       clamp_l, clamp_r;
    out_t       out_next [NUM_CH];
    out_t       out_reg  [NUM_CH];
    logic       last_o_reg;

    function automatic count_t eff_count(input count_t n, input count_t lim);
        count_t r;
        r = n;
        if (r == 4'd0) begin
            r = 4'd1;
        end
        if (r > lim) begin
            r = lim;
        end
        return r;
    endfunction

    function automatic out_t round_term(input prod_t p);
        logic        neg;
        logic [31:0] mag;
        logic [31:0] rnd;
        neg = p[31];
        mag = neg ? 32'(-p) : 32'(p);
        rnd = (mag + ROUND_ADD) >> MIX_SHIFT;
        return neg ? -out_t'(rnd[16:0]) : out_t'(rnd[16:0]);
    endfunction

    function automatic out_t clamp18(input logic signed [17:0] v);
        if (v > CLAMP_HI) begin
            return out_t'(CLAMP_HI[16:0]);
        end else if (v < CLAMP_LO) begin
            return out_t'(CLAMP_LO[16:0]);
        end
        return v[16:0];
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_reg <= CNT_RESET;
            dst_reg <= CNT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SRC_CHANNELS: src_reg <= cfg_data;
                REG_DST_CHANNELS: dst_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign adv_o   = !m_valid_reg || m_ready;
    assign adv3    = !v3_reg || adv_o;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= s_valid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
            if (adv3) begin
                v3_reg <= v2_reg;
            end
            if (adv_o) begin
                m_valid_reg <= v3_reg;
            end
        end
    end

    // Stage 1: mask unused source channels and decode the mix mode.
    always_comb begin
        in_smp[0] = s_sample_0;
        in_smp[1] = s_sample_1;
        in_smp[2] = s_sample_2;
        in_smp[3] = s_sample_3;
        in_smp[4] = s_sample_4;
        in_smp[5] = s_sample_5;
        in_smp[6] = s_sample_6;
        in_smp[7] = s_sample_7;
        ns = eff_count(src_reg, CNT_MAX);
        nd = eff_count(dst_reg, CNT_MAX);
        mix1_next = (nd == 4'd2) && (ns >= 4'd3);
        for (int i = 0; i < NUM_CH; i++) begin
            smp1_next[i]  = (count_t'(i) < ns) ? in_smp[i] : '0;
            keep1_next[i] = (count_t'(i) < nd);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            smp1_reg  <= smp1_next;
            keep1_reg <= keep1_next;
            mix1_reg  <= mix1_next;
            last1_reg <= s_frame_last;
        end
    end

    // Stage 2: scale center and rear channels by the mix gain.
    always_ff @(posedge aclk) begin
        if (adv2) begin
            smp2_reg   <= smp1_reg;
            keep2_reg  <= keep1_reg;
            mix2_reg   <= mix1_reg;
            last2_reg  <= last1_reg;
            prod_c_reg <= prod_t'(smp1_reg[2]) * prod_t'(MIX_GAIN);
            prod_l_reg <= prod_t'(smp1_reg[4]) * prod_t'(MIX_GAIN);
            prod_r_reg <= prod_t'(smp1_reg[5]) * prod_t'(MIX_GAIN);
        end
    end

    // Stage 3: round each scaled term on its own.
    always_comb begin
        term_c_next = round_term(prod_c_reg);
        term_l_next = round_term(prod_l_reg);
        term_r_next = round_term(prod_r_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv3) begin
            smp3_reg   <= smp2_reg;
            keep3_reg  <= keep2_reg;
            mix3_reg   <= mix2_reg;
            last3_reg  <= last2_reg;
            term_c_reg <= term_c_next;
            term_l_reg <= term_l_next;
            term_r_reg <= term_r_next;
        end
    end

    // Stage 4: sum, clamp and select the output frame.
    always_comb begin
        sum_l = 18'(smp3_reg[0]) + 18'(term_c_reg) + 18'(term_l_reg);
        sum_r = 18'(smp3_reg[1]) + 18'(term_c_reg) + 18'(term_r_reg);
        clamp_l = clamp18(sum_l);
        clamp_r = clamp18(sum_r);
        for (int i = 0; i < NUM_CH; i++) begin
            out_next[i] = keep3_reg[i] ? out_t'(smp3_reg[i]) : '0;
        end
        if (mix3_reg) begin
            out_next[0] = clamp_l;
            out_next[1] = clamp_r;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_o) begin
            out_reg    <= out_next;
            last_o_reg <= last3_reg;
        end
    end

    assign m_out_0    = out_reg[0];
    assign m_out_1    = out_reg[1];
    assign m_out_2    = out_reg[2];
    assign m_out_3    = out_reg[3];
    assign m_out_4    = out_reg[4];
    assign m_out_5    = out_reg[5];
    assign m_out_6    = out_reg[6];
    assign m_out_7    = out_reg[7];
    assign m_out_last = last_o_reg;

endmodule
